// ===== rtl/tfcr_pkg.sv =====
// Package for the framed command receiver: sizes, codes, types and profile defaults.
`timescale 1ns / 1ps

package tfcr_pkg;

  // Framing and timeout sizes
  localparam int WRAP_LENGTH   = 46;
  localparam int FRAME_LENGTH  = 10;
  localparam int IDLE_TICKS    = 5;
  localparam int PROFILE_COUNT = 6;
  localparam int PROFILE_BASE  = 3;

  // Position must hold the larger of the wrap point and the frame length
  localparam int POS_MAX = (WRAP_LENGTH > FRAME_LENGTH) ? WRAP_LENGTH : FRAME_LENGTH;
  localparam int POS_W   = $clog2(POS_MAX + 1);
  localparam int TMR_W   = $clog2(IDLE_TICKS + 1);
  localparam int FIDX_W  = $clog2(FRAME_LENGTH);

  // Frame constants
  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'h02;
  localparam logic [7:0] CMD_LOAD   = 8'h11;
  localparam logic [7:0] CMD_START  = 8'h12;

  // Status codes
  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_STARTED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  // Input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef logic [7:0] byte_t;
  typedef byte_t [FRAME_LENGTH-1:0]  frame_t;
  typedef byte_t [PROFILE_COUNT-1:0] profile_t;

  // Profile defaults, entry 0 in the lowest byte
  localparam profile_t PROFILE_RESET = {8'h32, 8'hf0, 8'h64, 8'hc8, 8'h5a, 8'h96};

  // Outcome of one frame check
  typedef struct packed {
    logic [1:0] status;
    logic       load;
    logic       start;
    profile_t   profile;
  } check_t;

endpackage

// ===== rtl/tfcr_check.sv =====
// Frame checker: header, truncated XOR checksum and command decode.
`timescale 1ns / 1ps

module tfcr_check (
  input  tfcr_pkg::frame_t frame,
  output tfcr_pkg::check_t result
);

  logic [7:0] acc;
  logic       alive;
  logic       hdr_ok;
  logic       sum_ok;

  // XOR of the leading bytes, stopping at the first zero byte
  always_comb begin
    acc   = '0;
    alive = 1'b1;
    for (int k = 0; k < tfcr_pkg::FRAME_LENGTH - 1; k++) begin
      if (frame[tfcr_pkg::FIDX_W'(k)] == 8'h00) begin
        alive = 1'b0;
      end
      if (alive) begin
        acc = acc ^ frame[tfcr_pkg::FIDX_W'(k)];
      end
    end
  end

  assign hdr_ok = (frame[0] == tfcr_pkg::HDR_FIRST) && (frame[1] == tfcr_pkg::HDR_SECOND);
  assign sum_ok = (frame[tfcr_pkg::FRAME_LENGTH-1] == acc);

  // Profile bytes and command decode; profile bytes that would overlap the
  // check byte read as zero
  always_comb begin
    for (int k = 0; k < tfcr_pkg::PROFILE_COUNT; k++) begin
      if (tfcr_pkg::PROFILE_BASE + k < tfcr_pkg::FRAME_LENGTH - 1) begin
        result.profile[k] = frame[tfcr_pkg::FIDX_W'(tfcr_pkg::PROFILE_BASE + k)];
      end else begin
        result.profile[k] = '0;
      end
    end
    result.load  = 1'b0;
    result.start = 1'b0;
    if (!(hdr_ok && sum_ok)) begin
      result.status = tfcr_pkg::ST_ERROR;
    end else if (frame[2] == tfcr_pkg::CMD_LOAD) begin
      result.status = tfcr_pkg::ST_LOADED;
      result.load   = 1'b1;
    end else if (frame[2] == tfcr_pkg::CMD_START) begin
      result.status = tfcr_pkg::ST_STARTED;
      result.start  = 1'b1;
    end else begin
      result.status = tfcr_pkg::ST_UNKNOWN;
    end
  end

endmodule

// ===== rtl/timeout_framed_command_receiver.sv =====
// Top level of the framed command receiver with idle timeout.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready | tuser: kind; tdata: rx_byte
//  out_    | out | out_tvalid/out_tready | tdata: status, was_started, 6 profile bytes
//
// One item per cycle sustained: an input register feeds a single pass of state
// update and frame check into the result register.
// A stalled result holds the block only once both registers are full.
// Synchronous active-low reset clears position, timer, start flag and both
// valid flags and loads the profile defaults; the frame store is not reset.
`timescale 1ns / 1ps

module timeout_framed_command_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] command (0 byte, 1 poll tick)
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [1:0] status, [2] was_started, [10:3] peak_temp_one,
                                  // [18:11] hold_time_one, [26:19] peak_temp_two,
                                  // [34:27] hold_time_two, [42:35] peak_temp_three,
                                  // [50:43] hold_time_three, [55:51] zero
);

  localparam int POS_W  = tfcr_pkg::POS_W;
  localparam int TMR_W  = tfcr_pkg::TMR_W;
  localparam int FIDX_W = tfcr_pkg::FIDX_W;

  // Input register
  logic              stg_valid_r;
  logic              stg_kind_r;
  logic [7:0]        stg_byte_r;

  // Receiver state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [TMR_W-1:0]  tmr_r, tmr_nxt;
  logic              start_r, start_nxt;
  tfcr_pkg::profile_t prof_r, prof_nxt;
  tfcr_pkg::frame_t  frame_r;

  // Result register
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_started_r;
  tfcr_pkg::profile_t out_prof_r;

  logic              out_free;
  logic              fire;
  logic              emit;
  logic [POS_W-1:0]  pos_eff;
  logic              store_byte;
  tfcr_pkg::check_t  chk;

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = stg_valid_r && out_free;
  assign in_tready = !stg_valid_r || out_free;

  tfcr_check u_check (
    .frame  (frame_r),
    .result (chk)
  );

  // Byte placement with wrap
  assign pos_eff    = (pos_r >= POS_W'(tfcr_pkg::WRAP_LENGTH)) ? '0 : pos_r;
  assign store_byte = fire && (stg_kind_r == tfcr_pkg::KIND_BYTE) &&
                      (pos_eff < POS_W'(tfcr_pkg::FRAME_LENGTH));

  // Frame is checked on the tick that runs the timer out with a full frame
  assign emit = fire && (stg_kind_r == tfcr_pkg::KIND_TICK) &&
                (tmr_r == TMR_W'(1)) && (pos_r == POS_W'(tfcr_pkg::FRAME_LENGTH));

  // Next state
  always_comb begin
    pos_nxt   = pos_r;
    tmr_nxt   = tmr_r;
    start_nxt = start_r;
    prof_nxt  = prof_r;
    if (fire) begin
      if (stg_kind_r == tfcr_pkg::KIND_BYTE) begin
        pos_nxt = pos_eff + POS_W'(1);
        tmr_nxt = TMR_W'(tfcr_pkg::IDLE_TICKS);
      end else if (tmr_r != '0) begin
        tmr_nxt = tmr_r - TMR_W'(1);
      end
    end
    if (emit) begin
      pos_nxt = '0;
      if (chk.load) begin
        prof_nxt = chk.profile;
      end
      if (chk.start) begin
        start_nxt = 1'b1;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      stg_kind_r <= in_tuser[0];
      stg_byte_r <= in_tdata;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      tmr_r   <= '0;
      start_r <= 1'b0;
      prof_r  <= tfcr_pkg::PROFILE_RESET;
    end else begin
      pos_r   <= pos_nxt;
      tmr_r   <= tmr_nxt;
      start_r <= start_nxt;
      prof_r  <= prof_nxt;
    end
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (store_byte) begin
      frame_r[pos_eff[FIDX_W-1:0]] <= stg_byte_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
    if (emit) begin
      out_status_r  <= chk.status;
      out_started_r <= start_r;
      out_prof_r    <= prof_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_prof_r, out_started_r, out_status_r};

  // Checks
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (pos_r == '0))
    else $error("position not cleared after frame check");

  a_tmr_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (tmr_r <= TMR_W'(tfcr_pkg::IDLE_TICKS)))
    else $error("idle timer above reload value");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (pos_r <= POS_W'(tfcr_pkg::POS_MAX)))
    else $error("position out of range");

  a_start_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(start_r))
    else $error("start flag dropped");

endmodule

// ===== tb/sv/tb_timeout_framed_command_receiver.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the framed command receiver: directed frames, then random traffic.

module tb_timeout_framed_command_receiver;

  localparam int DIR_ROWS        = 31;
  localparam int TARGET_ITEMS    = 950;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_AFTER      = 8;    // reports checked before the long receiver hold-off
  localparam int PAUSE_AT_SEQ    = 25;   // random sequence at which the sender drains
  localparam int SETTLE_CYCLES   = 8;
  localparam int TIMEOUT_NS      = 3_000_000;

  // One frame report as the block emits it
  typedef struct packed {
    logic [1:0]         status;
    logic               was_started;
    tfcr_pkg::profile_t profile;
  } report_t;

  // One row of the directed stimulus; golden is used only where typed is set
  typedef struct packed {
    logic            typed;
    logic            kind;
    tfcr_pkg::byte_t data;
    report_t         golden;
  } stim_row_t;

  localparam report_t NO_REPORT = '0;
  // Profile loaded by the extreme-value frame, entry 0 in the lowest byte
  localparam tfcr_pkg::profile_t EXTREME_PROFILE = {8'h00, 8'hfe, 8'h7f, 8'h80, 8'h01, 8'hff};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [0:0]  in_tuser;   // [0] command (0 byte, 1 poll tick)
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [1:0] status, [2] was_started, [50:3] six profile bytes

  always #5 clk = ~clk;

  timeout_framed_command_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predicted receiver state
  logic [tfcr_pkg::POS_W-1:0] rx_pos;
  tfcr_pkg::frame_t           frame_store;
  logic [tfcr_pkg::TMR_W-1:0] idle_cnt;
  logic                       start_seen;
  tfcr_pkg::profile_t         profile_now;

  report_t pending_reports[$];

  int  err_count = 0;
  int  items_sent = 0;
  int  bytes_sent = 0;
  int  ticks_sent = 0;
  int  reports_checked = 0;
  int  burst_left = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  bit  hold_done = 1'b0;

  string profile_field [tfcr_pkg::PROFILE_COUNT] = '{"peak_temp_one", "hold_time_one",
                                                     "peak_temp_two", "hold_time_two",
                                                     "peak_temp_three", "hold_time_three"};

  // Directed part: idle tick, load frame with extreme bytes, start frame of zero payload
  stim_row_t directed_rows [DIR_ROWS] = '{
    {1'b0, tfcr_pkg::KIND_TICK, 8'h00,               NO_REPORT},  // tick, timer at zero
    {1'b0, tfcr_pkg::KIND_BYTE, tfcr_pkg::HDR_FIRST,  NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, tfcr_pkg::HDR_SECOND, NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, tfcr_pkg::CMD_LOAD,   NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'hff,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h01,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h80,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h7f,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'hfe,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h00,               NO_REPORT},  // zero ends checksum run
    {1'b0, tfcr_pkg::KIND_BYTE, 8'hb9,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_TICK, 8'hff,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_TICK, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_TICK, 8'hff,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_TICK, 8'h00,               NO_REPORT},
    {1'b1, tfcr_pkg::KIND_TICK, 8'h00, tfcr_pkg::ST_LOADED, 1'b0, EXTREME_PROFILE},
    {1'b0, tfcr_pkg::KIND_BYTE, tfcr_pkg::HDR_FIRST,  NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, tfcr_pkg::HDR_SECOND, NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, tfcr_pkg::CMD_START,  NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_BYTE, 8'h45,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_TICK, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_TICK, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_TICK, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_TICK, 8'h00,               NO_REPORT},
    {1'b0, tfcr_pkg::KIND_TICK, 8'h00,               NO_REPORT}
  };

  // XOR of the bytes ahead of the check byte, stopping at the first zero byte
  function automatic tfcr_pkg::byte_t frame_xor(input tfcr_pkg::frame_t f);
    tfcr_pkg::byte_t acc;
    bit              stop;
    acc  = '0;
    stop = 1'b0;
    for (int k = 0; k < tfcr_pkg::FRAME_LENGTH - 1; k++) begin
      if (f[k] == 8'h00) stop = 1'b1;
      if (!stop) acc ^= f[k];
    end
    return acc;
  endfunction

  // Advance the predicted state by one accepted item
  task automatic step_receiver(input logic kind, input tfcr_pkg::byte_t data,
                               output bit made, output report_t rpt);
    made = 1'b0;
    rpt  = '0;
    if (kind == tfcr_pkg::KIND_BYTE) begin
      if (rx_pos >= tfcr_pkg::WRAP_LENGTH) rx_pos = '0;
      if (rx_pos < tfcr_pkg::FRAME_LENGTH)
        frame_store[rx_pos[tfcr_pkg::FIDX_W-1:0]] = data;
      rx_pos   = rx_pos + 1'b1;
      idle_cnt = tfcr_pkg::TMR_W'(tfcr_pkg::IDLE_TICKS);
    end else if (idle_cnt != 0) begin
      idle_cnt = idle_cnt - 1'b1;
      if (idle_cnt == 0 && rx_pos == tfcr_pkg::FRAME_LENGTH) begin
        made = 1'b1;
        rpt.was_started = start_seen;
        if (frame_store[0] != tfcr_pkg::HDR_FIRST || frame_store[1] != tfcr_pkg::HDR_SECOND ||
            frame_store[tfcr_pkg::FRAME_LENGTH-1] != frame_xor(frame_store)) begin
          rpt.status = tfcr_pkg::ST_ERROR;
        end else if (frame_store[2] == tfcr_pkg::CMD_LOAD) begin
          // profile bytes at or past the check byte read as zero
          for (int k = 0; k < tfcr_pkg::PROFILE_COUNT; k++)
            profile_now[k] = (tfcr_pkg::PROFILE_BASE + k < tfcr_pkg::FRAME_LENGTH - 1) ?
                             frame_store[tfcr_pkg::PROFILE_BASE + k] : 8'h00;
          rpt.status = tfcr_pkg::ST_LOADED;
        end else if (frame_store[2] == tfcr_pkg::CMD_START) begin
          start_seen = 1'b1;
          rpt.status = tfcr_pkg::ST_STARTED;
        end else begin
          rpt.status = tfcr_pkg::ST_UNKNOWN;
        end
        rpt.profile = profile_now;
        rx_pos = '0;
      end
    end
  endtask

  // Offer one item in bursts with random gaps; predict once it is taken
  task automatic send_item(input logic kind, input tfcr_pkg::byte_t data,
                           input bit typed, input report_t golden);
    int      gap;
    bit      made;
    report_t rpt;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (in_tready !== 1'b1);
    step_receiver(kind, data, made, rpt);
    items_sent++;
    if (kind == tfcr_pkg::KIND_BYTE) bytes_sent++;
    else ticks_sent++;
    if (made) begin
      pending_reports.push_back(typed ? golden : rpt);
    end
  endtask

  task automatic send_byte(input tfcr_pkg::byte_t b);
    send_item(tfcr_pkg::KIND_BYTE, b, 1'b0, NO_REPORT);
  endtask

  // Ticks carry random data to show the byte field is ignored
  task automatic send_ticks(input int n);
    repeat (n) send_item(tfcr_pkg::KIND_TICK, 8'($urandom_range(255)), 1'b0, NO_REPORT);
  endtask

  // Well-formed frame with random content, occasionally damaged
  task automatic send_frame();
    tfcr_pkg::frame_t f;
    f[0] = tfcr_pkg::HDR_FIRST;
    f[1] = tfcr_pkg::HDR_SECOND;
    case ($urandom_range(3))
      1:       f[2] = tfcr_pkg::CMD_START;
      2:       f[2] = 8'($urandom_range(255));
      default: f[2] = tfcr_pkg::CMD_LOAD;
    endcase
    for (int k = tfcr_pkg::PROFILE_BASE; k < tfcr_pkg::FRAME_LENGTH - 1; k++)
      f[k] = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
    if ($urandom_range(9) == 0)
      f[tfcr_pkg::FIDX_W'($urandom_range(1))] = 8'($urandom_range(255));
    f[tfcr_pkg::FRAME_LENGTH-1] = frame_xor(f);
    if ($urandom_range(7) == 0) f[tfcr_pkg::FRAME_LENGTH-1] ^= 8'($urandom_range(1, 255));
    // run the position past the wrap point so the frame lands at zero
    if (rx_pos != 0 && rx_pos < tfcr_pkg::WRAP_LENGTH)
      repeat (tfcr_pkg::WRAP_LENGTH - rx_pos) send_byte(8'($urandom_range(255)));
    for (int k = 0; k < tfcr_pkg::FRAME_LENGTH; k++) begin
      send_byte(f[k]);
      if ($urandom_range(9) == 0) send_ticks($urandom_range(1, tfcr_pkg::IDLE_TICKS - 1));
    end
    send_ticks(tfcr_pkg::IDLE_TICKS + $urandom_range(2));
  endtask

  // Stimulus
  initial begin
    int seq;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= tfcr_pkg::KIND_BYTE;
    in_tdata    <= '0;
    rx_pos      = '0;
    frame_store = '0;
    idle_cnt    = '0;
    start_seen  = 1'b0;
    profile_now = tfcr_pkg::PROFILE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      send_item(directed_rows[r].kind, directed_rows[r].data,
                directed_rows[r].typed, directed_rows[r].golden);

    seq = 0;
    while (items_sent < TARGET_ITEMS) begin
      seq++;
      if (seq == PAUSE_AT_SEQ) begin
        // hold the sender until every predicted report is out
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
      end
      case ($urandom_range(19))
        0, 1: begin
          repeat ($urandom_range(1, 14)) send_byte(8'($urandom_range(255)));
          send_ticks($urandom_range(7));
        end
        2: begin
          repeat ($urandom_range(20, 60)) send_byte(8'($urandom_range(255)));
          send_ticks(tfcr_pkg::IDLE_TICKS);
        end
        3:       send_ticks($urandom_range(1, 4));
        default: send_frame();
      endcase
    end
    in_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d bytes, %0d poll ticks), checked %0d frame reports.",
             items_sent, bytes_sent, ticks_sent, reports_checked);
    $display("Reports by status: loaded %0d, started %0d, unknown %0d, error %0d.",
             status_seen[tfcr_pkg::ST_LOADED], status_seen[tfcr_pkg::ST_STARTED],
             status_seen[tfcr_pkg::ST_UNKNOWN], status_seen[tfcr_pkg::ST_ERROR]);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Compare one report with the oldest prediction
  task automatic check_report(input logic [55:0] word);
    report_t want;
    if (pending_reports.size() == 0) begin
      err_count++;
      $display("%0t: unexpected report: expected none, got %h", $time, word);
    end else begin
      want = pending_reports.pop_front();
      reports_checked++;
      status_seen[want.status]++;
      if (word[1:0] !== want.status) begin
        err_count++;
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, word[1:0]);
      end
      if (word[2] !== want.was_started) begin
        err_count++;
        $display("%0t: was_started mismatch: expected %0b, got %0b",
                 $time, want.was_started, word[2]);
      end
      for (int k = 0; k < tfcr_pkg::PROFILE_COUNT; k++) begin
        if (word[3 + 8*k +: 8] !== want.profile[k]) begin
          err_count++;
          $display("%0t: %s mismatch: expected %02h, got %02h",
                   $time, profile_field[k], want.profile[k], word[3 + 8*k +: 8]);
        end
      end
    end
  endtask

  // Result side: check each taken report, stall on a changing pattern
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) check_report(out_tdata);
      // one long hold-off so both internal registers fill and input stalls
      if (!hold_done && reports_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (rst_n !== 1'b1) begin
        out_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(1));
          2:       out_tready <= ($urandom_range(3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tfcr_pkg.sv
rtl/tfcr_check.sv
rtl/timeout_framed_command_receiver.sv
tb/sv/tb_timeout_framed_command_receiver.sv
